// File: hdl/assert_macros.svh
// Assertion helpers for the slot allocator.
// Uses clk and rst from the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_ON_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/fsla_pkg.sv
// Shared types and codes for the free-list slot allocator.
// No dependencies.
package fsla_pkg;

  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_FREE  = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] result_slot;
    logic [CNT_W-1:0] occupied_count;
  } rsp_t;

endpackage

// File: hdl/fsla_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module fsla_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/fifo_free_list_slot_allocator.sv
// Slot pool allocator with a FIFO free list held as links in RAM.
// Depends on fsla_pkg, fsla_ram and assert_macros.svh.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------
//  req     | in  | req_valid / req_ready  | fsla_pkg::req_t (command, slot)
//  rsp     | out | rsp_valid / rsp_ready  | fsla_pkg::rsp_t (status, slot,
//          |     |                        |   occupied count)
//
// Each beat first reads the link and mark RAMs, then updates them and
// loads the output register.
// After reset an init pass writes the link chain and clears the marks;
// req_ready stays low meanwhile.
// A new request is taken while a response waits; the update cycle holds
// until the output register is free.
`include "assert_macros.svh"

module fifo_free_list_slot_allocator #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  fsla_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fsla_pkg::rsp_t rsp
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (CW > fsla_pkg::IDX_W) ? CW : fsla_pkg::IDX_W;

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC} state_t;

  state_t         state;
  logic [SW-1:0]  init_cnt;
  logic [1:0]     cmd;
  logic           idx_ok;
  logic [SW-1:0]  idx_addr;
  logic [fsla_pkg::IDX_W-1:0] idx_echo;
  logic [SW-1:0]  free_head, free_head_next;
  logic [SW-1:0]  free_tail, free_tail_next;
  logic           free_list_empty, free_list_empty_next;
  logic [CW-1:0]  used_count, used_count_next;
  fsla_pkg::rsp_t rsp_next;

  logic           req_fire, commit;
  logic [XW-1:0]  req_idx_x;

  logic           link_we, mark_we, mark_wdata, mark_rdata;
  logic [SW-1:0]  link_waddr, link_wdata, link_rdata, mark_waddr;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign commit    = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign req_idx_x = XW'(req.slot_index);

  // Link of the tail entry is never followed, so freeing skips its end mark.
  fsla_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (req_fire),
    .raddr (free_head),
    .rdata (link_rdata)
  );

  fsla_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (req_fire),
    .raddr (req_idx_x[SW-1:0]),
    .rdata (mark_rdata)
  );

  always_comb begin
    free_head_next       = free_head;
    free_tail_next       = free_tail;
    free_list_empty_next = free_list_empty;
    used_count_next      = used_count;
    rsp_next.status         = fsla_pkg::ST_OK;
    rsp_next.result_slot    = idx_echo;
    link_we    = 1'b0;
    link_waddr = free_tail;
    link_wdata = idx_addr;
    mark_we    = 1'b0;
    mark_waddr = idx_addr;
    mark_wdata = 1'b0;

    if (state == S_INIT) begin
      link_we    = 1'b1;
      link_waddr = init_cnt;
      link_wdata = init_cnt + 1'b1;
      mark_we    = 1'b1;
      mark_waddr = init_cnt;
    end else if (commit) begin
      unique case (cmd)
        fsla_pkg::CMD_ALLOC: begin
          if (free_list_empty) begin
            rsp_next.status      = fsla_pkg::ST_FULL;
            rsp_next.result_slot = '0;
          end else begin
            rsp_next.result_slot = fsla_pkg::IDX_W'(free_head);
            if (free_head == free_tail) begin
              free_list_empty_next = 1'b1;
            end else begin
              free_head_next = link_rdata;
            end
            mark_we         = 1'b1;
            mark_waddr      = free_head;
            mark_wdata      = 1'b1;
            used_count_next = used_count + 1'b1;
          end
        end
        fsla_pkg::CMD_FREE: begin
          if (!idx_ok || !mark_rdata) begin
            rsp_next.status = fsla_pkg::ST_BAD_FREE;
          end else begin
            mark_we = 1'b1;
            if (free_list_empty) begin
              free_head_next       = idx_addr;
              free_list_empty_next = 1'b0;
            end else begin
              link_we = 1'b1;
            end
            free_tail_next = idx_addr;
            if (used_count != '0) begin
              used_count_next = used_count - 1'b1;
            end
          end
        end
        fsla_pkg::CMD_QUERY: begin
          if (!idx_ok || !mark_rdata) begin
            rsp_next.status = fsla_pkg::ST_NOT_ALLOC;
          end
        end
        default: begin
        end
      endcase
    end
    rsp_next.occupied_count = fsla_pkg::CNT_W'(used_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_INIT;
      init_cnt        <= '0;
      free_head       <= '0;
      free_tail       <= SW'(SLOTS - 1);
      free_list_empty <= 1'b0;
      used_count      <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == SW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            state    <= S_EXEC;
            cmd      <= req.command;
            idx_ok   <= (req_idx_x < XW'(SLOTS));
            idx_addr <= req_idx_x[SW-1:0];
            idx_echo <= req.slot_index;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state           <= S_IDLE;
            free_head       <= free_head_next;
            free_tail       <= free_tail_next;
            free_list_empty <= free_list_empty_next;
            used_count      <= used_count_next;
            rsp             <= rsp_next;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  `ASSERT_ON_RUN(a_count_bound, used_count <= CW'(SLOTS), "occupied count above pool size")
  `ASSERT_ON_RUN(a_empty_full, free_list_empty == (used_count == CW'(SLOTS)), "bad empty flag")
  `ASSERT_ON_RUN(a_fire_exec, req_fire |=> state == S_EXEC, "accepted beat did not enter update")
  `ASSERT_ON_RUN(a_rsp_src, $rose(rsp_valid) |-> $past(state == S_EXEC), "stray response")

endmodule
